>>> hw/rtl/eeprom_emulation_log_store_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the log store core
// Shared concurrent check macros; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef EEPROM_EMULATION_LOG_STORE_CORE_DEFINES_SVH
`define EEPROM_EMULATION_LOG_STORE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define EELS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// expression must never be true out of reset
`define EELS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define EELS_ASSERT(lbl, clk, rst_n, prop)
`define EELS_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> hw/rtl/eels_pkg.sv
// ---------------------------------------------------------------------------
// eels_pkg
// Constants and controller/datapath command and status types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package eels_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int KEY_W     = 4;
    localparam int NKEYS     = 16;
    localparam int VAL_W     = 16;

    localparam logic [VAL_W-1:0] EMPTY_VALUE = '1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;        // latch input word, read its mapped slot
        logic rd_comp;       // read the slot under the compaction index
        logic comp_start;    // clear map and fill, remember old fill
        logic comp_step;     // rewrite or drop the slot just read
        logic append;        // write the latched word into a new slot
        logic ld_out;        // load the result register
        logic res_read;
        logic res_appended;
        logic res_compacted;
        logic res_dropped;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_write;      // latched opcode is a write
        logic eq;            // latched value equals the key's current value
        logic full;          // last usable slot taken
        logic last;          // compaction index at the old fill
        logic out_free;      // result register can take a new word
    } t_status;

endpackage

>>> hw/rtl/eels_if.sv
// ---------------------------------------------------------------------------
// eels_if
// Valid/ready channels for request and response words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface eels_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [eels_pkg::KEY_W-1:0]  key;
    logic [eels_pkg::VAL_W-1:0]  value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface eels_out_if;
    logic                        valid;
    logic                        ready;
    logic [eels_pkg::VAL_W-1:0]  read_value;
    logic                        appended;
    logic                        compacted;
    logic                        dropped;

    modport source (output valid, output read_value, output appended, output compacted,
                    output dropped, input ready);
    modport sink   (input valid, input read_value, input appended, input compacted,
                    input dropped, output ready);
endinterface

>>> hw/rtl/eels_datapath.sv
// ---------------------------------------------------------------------------
// eels_datapath
// Slot memories, key-to-slot map, fill count and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eeprom_emulation_log_store_core_defines.svh"

module eels_datapath #(
    parameter int SLOTS = eels_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  eels_pkg::t_cmd              i_cmd,
    output eels_pkg::t_status           o_status,
    input  logic                        i_in_opcode,
    input  logic [eels_pkg::KEY_W-1:0]  i_in_key,
    input  logic [eels_pkg::VAL_W-1:0]  i_in_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [eels_pkg::VAL_W-1:0]  o_read_value,
    output logic                        o_appended,
    output logic                        o_compacted,
    output logic                        o_dropped
);

    localparam int SW = $clog2(SLOTS);

    // slot memories; only slots 1..fill are ever read back
    logic [eels_pkg::KEY_W-1:0] r_mem_key [SLOTS];
    logic [eels_pkg::VAL_W-1:0] r_mem_val [SLOTS];

    logic [SW-1:0]              r_map [eels_pkg::NKEYS];
    logic [SW-1:0]              r_fill;
    logic [SW-1:0]              r_last;
    logic [SW-1:0]              r_idx;

    logic                       r_op;
    logic [eels_pkg::KEY_W-1:0] r_key;
    logic [eels_pkg::VAL_W-1:0] r_value;

    logic [eels_pkg::KEY_W-1:0] r_rd_key;
    logic [eels_pkg::VAL_W-1:0] r_rd_val;
    logic                       r_rd_zero;

    logic                       r_out_valid;
    logic [eels_pkg::VAL_W-1:0] r_out_read_value;
    logic                       r_out_appended;
    logic                       r_out_compacted;
    logic                       r_out_dropped;

    logic [SW-1:0]              fill_inc;
    logic [eels_pkg::VAL_W-1:0] cur;
    logic [SW-1:0]              hit_slot;
    logic                       comp_new;
    logic                       comp_we;
    logic                       we;
    logic [SW-1:0]              wr_addr;
    logic [eels_pkg::KEY_W-1:0] wr_key;
    logic [eels_pkg::VAL_W-1:0] wr_val;
    logic                       rd_en;
    logic [SW-1:0]              rd_addr;
    logic                       full;

    // address and data selection
    always_comb begin
        fill_inc = r_fill + SW'(1);
        cur      = r_rd_zero ? eels_pkg::EMPTY_VALUE : r_rd_val;
        hit_slot = r_map[r_rd_key];
        comp_new = (hit_slot == '0);
        // a key whose first surviving entry is empty gets no slot yet
        comp_we  = i_cmd.comp_step && !(comp_new && (r_rd_val == eels_pkg::EMPTY_VALUE));
        we       = i_cmd.append || comp_we;
        if (i_cmd.append) begin
            wr_addr = fill_inc;
            wr_key  = r_key;
            wr_val  = r_value;
        end else begin
            wr_addr = comp_new ? fill_inc : hit_slot;
            wr_key  = r_rd_key;
            wr_val  = r_rd_val;
        end
        rd_en   = i_cmd.accept || i_cmd.rd_comp;
        rd_addr = i_cmd.rd_comp ? r_idx : r_map[i_in_key];
        full    = (r_fill == SW'(SLOTS - 1));
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_key[wr_addr] <= wr_key;
            r_mem_val[wr_addr] <= wr_val;
        end
        if (rd_en) begin
            r_rd_key  <= r_mem_key[rd_addr];
            r_rd_val  <= r_mem_val[rd_addr];
            r_rd_zero <= (rd_addr == '0);
        end
    end

    // hold the accepted request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_opcode;
            r_key   <= i_in_key;
            r_value <= i_in_value;
        end
    end

    // map, fill count and compaction walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < eels_pkg::NKEYS; k++) begin
                r_map[k] <= '0;
            end
            r_fill <= '0;
            r_last <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.comp_start) begin
                for (int k = 0; k < eels_pkg::NKEYS; k++) begin
                    r_map[k] <= '0;
                end
                r_fill <= '0;
                r_last <= r_fill;
                r_idx  <= SW'(1);
            end
            if (i_cmd.comp_step) begin
                r_idx <= r_idx + SW'(1);
                if (comp_we && comp_new) begin
                    r_map[r_rd_key] <= fill_inc;
                    r_fill          <= fill_inc;
                end
            end
            if (i_cmd.append) begin
                r_map[r_key] <= fill_inc;
                r_fill       <= fill_inc;
            end
        end
    end

    // result register, freed when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_read_value <= i_cmd.res_read ? cur : '0;
            r_out_appended   <= i_cmd.res_appended;
            r_out_compacted  <= i_cmd.res_compacted;
            r_out_dropped    <= i_cmd.res_dropped;
        end
    end

    assign o_status.is_write = (r_op == eels_pkg::OP_WRITE);
    assign o_status.eq       = (r_value == cur);
    assign o_status.full     = full;
    assign o_status.last     = (r_idx == r_last);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_read_value;
    assign o_appended   = r_out_appended;
    assign o_compacted  = r_out_compacted;
    assign o_dropped    = r_out_dropped;

    // compaction rewrites in place: never ahead of the slot being read
    `EELS_ASSERT(a_comp_in_place, i_clk, i_rst_n, comp_we |-> (wr_addr <= r_idx))
    // an append always finds a free slot
    `EELS_NEVER(a_append_when_full, i_clk, i_rst_n, i_cmd.append && full)
    // a waiting result is never overwritten
    `EELS_ASSERT(a_load_when_free, i_clk, i_rst_n,
                 i_cmd.ld_out |-> (!r_out_valid || i_out_ready))

endmodule

>>> hw/rtl/eels_ctrl.sv
// ---------------------------------------------------------------------------
// eels_ctrl
// Sequencer for lookup, append and in-place compaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eeprom_emulation_log_store_core_defines.svh"

module eels_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  eels_pkg::t_status  i_status,
    output eels_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CRD,
        S_CWR,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.is_write && !i_status.eq && i_status.full) begin
                    o_cmd.comp_start = 1'b1;
                    n_state          = S_CRD;
                end else if (i_status.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                    if (!i_status.is_write) begin
                        o_cmd.res_read = 1'b1;
                    end else if (!i_status.eq) begin
                        o_cmd.append       = 1'b1;
                        o_cmd.res_appended = 1'b1;
                    end
                end
            end
            S_CRD: begin
                o_cmd.rd_comp = 1'b1;
                n_state       = S_CWR;
            end
            S_CWR: begin
                o_cmd.comp_step = 1'b1;
                n_state         = i_status.last ? S_FIN : S_CRD;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.ld_out        = 1'b1;
                    o_cmd.res_compacted = 1'b1;
                    n_state             = S_IDLE;
                    if (i_status.full) begin
                        o_cmd.res_dropped = 1'b1;
                    end else begin
                        o_cmd.append       = 1'b1;
                        o_cmd.res_appended = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // compaction only for a changing write into a full log
    `EELS_ASSERT(a_comp_needed, i_clk, i_rst_n,
                 o_cmd.comp_start |-> (i_status.is_write && !i_status.eq && i_status.full))
    // the walk ends right after the last old slot
    `EELS_ASSERT(a_walk_ends, i_clk, i_rst_n,
                 (r_state == S_CWR && i_status.last) |=> (r_state == S_FIN))

endmodule

>>> hw/rtl/eeprom_emulation_log_store_core.sv
// Emulated-EEPROM variable store kept as an append-only log of SLOTS key/value
// slots, slot 0 reserved. A read or a write first reads the key's mapped slot
// from the slot memory, then compares and appends once the result register is
// free. When the log is full, a changing write first compacts the log in place,
// walking the old slots through the single memory read and write port, reading
// and then rewriting or dropping each slot in turn. Input is held off during
// that walk. The result register lets the next word be accepted while a result
// waits. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
// eeprom_emulation_log_store_core
// Top level: controller, datapath and channel wiring.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module eeprom_emulation_log_store_core #(
    parameter int SLOTS = eels_pkg::SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eels_in_if.sink   i_req,
    eels_out_if.source o_rsp
);

    eels_pkg::t_cmd    cmd;
    eels_pkg::t_status status;
    logic              in_ready;

    // sequencer
    eels_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // storage and result register
    eels_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_opcode  (i_req.opcode),
        .i_in_key     (i_req.key),
        .i_in_value   (i_req.value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_read_value (o_rsp.read_value),
        .o_appended   (o_rsp.appended),
        .o_compacted  (o_rsp.compacted),
        .o_dropped    (o_rsp.dropped)
    );

    assign i_req.ready = in_ready;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives read and write request words into the log store core, keeps a
// shadow copy of the slot log and key map, and checks every response word
// against the shadow in order, under random idling on both channels.
// ---------------------------------------------------------------------------

module testbench;
    import eels_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int RAND_WORDS = 1400;
    localparam int QUIET_MAX  = 3000;
    localparam int TAIL       = 2 * SLOTS + 8;

    typedef struct {
        logic [VAL_W-1:0] read_value;
        logic             appended;
        logic             compacted;
        logic             dropped;
    } rsp_word_t;

    // shadow of the slot log; predicts one response word per request word
    class log_store_shadow;
        logic [KEY_W-1:0] slot_key [SLOTS];
        logic [VAL_W-1:0] slot_val [SLOTS];
        int unsigned      key_slot [NKEYS];
        int unsigned      fill;
        rsp_word_t        due [$];
        int unsigned      fails;
        int unsigned      drops;

        function new();
            wipe_log();
            fails = 0;
            drops = 0;
        endfunction

        function void wipe_log();
            fill = 0;
            foreach (key_slot[k]) key_slot[k] = 0;
            foreach (slot_val[s]) begin
                slot_key[s] = '0;
                slot_val[s] = EMPTY_VALUE;
            end
        endfunction

        function logic [VAL_W-1:0] value_of(input logic [KEY_W-1:0] key);
            return slot_val[key_slot[key]];
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        function void note_request(input logic op, input logic [KEY_W-1:0] key,
                                   input logic [VAL_W-1:0] value);
            rsp_word_t        w;
            logic [KEY_W-1:0] old_key [SLOTS];
            logic [VAL_W-1:0] old_val [SLOTS];
            logic [KEY_W-1:0] k;
            int unsigned      last;
            w = '{default: '0};
            if (op == OP_READ) begin
                w.read_value = value_of(key);
            end else if (value != value_of(key)) begin
                // full log: rebuild it with one slot per live key
                if (fill >= SLOTS - 1) begin
                    old_key = slot_key;
                    old_val = slot_val;
                    last    = fill;
                    wipe_log();
                    for (int s = 1; s <= last && s < SLOTS; s++) begin
                        k = old_key[s];
                        if (key_slot[k] == 0) begin
                            // a key whose first entry is empty stays out
                            if (old_val[s] == EMPTY_VALUE) continue;
                            fill++;
                            key_slot[k] = fill;
                        end
                        slot_key[key_slot[k]] = k;
                        slot_val[key_slot[k]] = old_val[s];
                    end
                    w.compacted = 1'b1;
                end
                if (fill < SLOTS - 1) begin
                    fill++;
                    key_slot[key]  = fill;
                    slot_key[fill] = key;
                    slot_val[fill] = value;
                    w.appended     = 1'b1;
                end else begin
                    w.dropped = 1'b1;
                    drops++;
                end
            end
            due.push_back(w);
        endfunction

        function void check_response(input rsp_word_t got);
            rsp_word_t want;
            if (due.size() == 0) begin
                $error("response word arrived with none expected");
                fails++;
                return;
            end
            want = due.pop_front();
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                fails++;
            end
            if (got.appended !== want.appended) begin
                $error("appended: expected %b, got %b", want.appended, got.appended);
                fails++;
            end
            if (got.compacted !== want.compacted) begin
                $error("compacted: expected %b, got %b", want.compacted, got.compacted);
                fails++;
            end
            if (got.dropped !== want.dropped) begin
                $error("dropped: expected %b, got %b", want.dropped, got.dropped);
                fails++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm         = 1'b0;
    bit   sender_gappy = 1'b1;

    log_store_shadow shadow = new();

    eels_in_if  req ();
    eels_out_if rsp ();

    eeprom_emulation_log_store_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #5 i_clk = ~i_clk;

    // offer one request word, with an optional idle burst ahead of it
    task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        if (!calm && sender_gappy && $urandom_range(0, 4) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.key    <= key;
        req.value  <= value;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        shadow.note_request(op, key, value);
    endtask

    // stimulus
    initial begin
        int               pool;
        int               pick;
        int               guard;
        logic [KEY_W-1:0] key;
        req.valid  = 1'b0;
        req.opcode = OP_READ;
        req.key    = '0;
        req.value  = '0;
        pool       = 14;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty reads, unchanged writes, empty value on a mapped key
        send_word(OP_READ,  4'd0,  16'h0000);
        send_word(OP_WRITE, 4'd15, EMPTY_VALUE);
        send_word(OP_WRITE, 4'd0,  16'h0000);
        send_word(OP_READ,  4'd0,  16'hFFFF);
        send_word(OP_WRITE, 4'd0,  16'h0000);
        send_word(OP_WRITE, 4'd15, 16'h8000);
        send_word(OP_READ,  4'd15, 16'h0000);
        send_word(OP_WRITE, 4'd15, EMPTY_VALUE);
        send_word(OP_READ,  4'd15, 16'h0000);
        // fill the log and compact it twice; key 15 keeps a slot holding the empty value
        for (int k = 1; k <= 13; k++)
            send_word(OP_WRITE, KEY_W'(k), (k == 1) ? 16'hFFFE : {4'(k), 12'h0F0});
        send_word(OP_WRITE, 4'd13, EMPTY_VALUE);
        send_word(OP_READ,  4'd15, 16'h0000);

        // random words; live keys stay below 14 so the log never jams
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 64 == 0) begin
                sender_gappy = ($urandom_range(0, 3) != 0);
                pool         = $urandom_range(2, 14);
            end
            if (n == RAND_WORDS / 2) begin
                // hold off until every response word is back
                req.valid <= 1'b0;
                do @(posedge i_clk); while (shadow.pending() != 0);
            end
            pick = $urandom_range(0, 99);
            key  = KEY_W'($urandom_range(0, pool - 1));
            if (pick < 30)
                send_word(OP_READ, KEY_W'($urandom_range(0, NKEYS - 1)),
                          VAL_W'($urandom_range(0, 16'hFFFF)));
            else if (pick < 42)
                send_word(OP_WRITE, KEY_W'($urandom_range(0, NKEYS - 1)), EMPTY_VALUE);
            else if (pick < 52)
                send_word(OP_WRITE, key, shadow.value_of(key));
            else if (pick < 76)
                send_word(OP_WRITE, key, VAL_W'($urandom_range(0, 16'hFFFE)));
            else
                send_word(OP_WRITE, key, VAL_W'($urandom_range(0, 7)));
        end

        // last stretch: no idling; fill with fifteen live keys until writes drop
        calm  = 1'b1;
        guard = 0;
        while (shadow.drops < 3 && guard < 400) begin
            send_word(OP_WRITE, KEY_W'(guard % 15), VAL_W'($urandom_range(0, 16'hFFFE)));
            guard++;
        end
        for (int n = 0; n < NKEYS; n++) begin
            send_word(OP_READ,  KEY_W'(n), 16'h0000);
            send_word(OP_WRITE, KEY_W'(n), VAL_W'($urandom_range(0, 16'hFFFF)));
        end

        // drain and let the core settle
        req.valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
        repeat (TAIL) @(posedge i_clk);
        if (shadow.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // response side: check each word, stall in bursts, hold off once for long
    initial begin
        int        stall;
        int        seen;
        int        cyc;
        bit        steady;
        bit        held;
        rsp_word_t got;
        stall     = 0;
        seen      = 0;
        cyc       = 0;
        steady    = 1'b0;
        held      = 1'b0;
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp.valid && rsp.ready) begin
                got.read_value = rsp.read_value;
                got.appended   = rsp.appended;
                got.compacted  = rsp.compacted;
                got.dropped    = rsp.dropped;
                shadow.check_response(got);
                seen++;
            end
            cyc++;
            if (cyc % 80 == 0) steady = ($urandom_range(0, 2) == 0);
            if (i_rst_n !== 1'b1) begin
                rsp.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                rsp.ready <= 1'b0;
            end else if (seen >= 500 && !held) begin
                held  = 1'b1;
                stall = 149;
                rsp.ready <= 1'b0;
            end else if (!calm && !steady && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 5);
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // watchdog: give up after a long run of cycles with no word moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || i_rst_n !== 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
